@@ rtl/core/stld_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stld_pkg
// Types and constants shared by the start/type/size frame deframer.
// ----------------------------------------------------------------------------
package stld_pkg;

    localparam int PAYLOAD_LIMIT = 64;

    localparam logic [7:0] SYNC_BYTE_RESET   = 8'd170;
    localparam logic [6:0] MAX_PAYLOAD_RESET = 7'd64;

    localparam logic [0:0] CFG_SYNC_BYTE   = 1'b0;
    localparam logic [0:0] CFG_MAX_PAYLOAD = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_TYPE = 3'd1,
        PH_SIZE = 3'd2,
        PH_DATA = 3'd3,
        PH_SKIP = 3'd4
    } stld_phase_t;

    typedef enum logic [1:0] {
        ST_BUSY = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } stld_status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_packet;
    } stld_in_t;

    typedef struct packed {
        logic         data_valid;
        logic [7:0]   payload_byte;
        logic [5:0]   byte_index;
        logic [7:0]   message_type;
        logic [7:0]   message_size;
        stld_status_t status;
    } stld_out_t;

    typedef struct packed {
        logic     valid;
        stld_in_t beat;
    } stld_stage_t;

    typedef struct packed {
        logic [7:0] sync_byte;
        logic [6:0] max_payload;
    } stld_cfg_t;

endpackage

@@ rtl/core/stld_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stld_cfg_regs
// Configuration register file: start byte and payload size limit.
// ----------------------------------------------------------------------------
module stld_cfg_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [0:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    output stld_pkg::stld_cfg_t cfg
);

    logic [7:0] sync_byte_reg;
    logic [6:0] max_payload_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_byte_reg   <= stld_pkg::SYNC_BYTE_RESET;
            max_payload_reg <= stld_pkg::MAX_PAYLOAD_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                stld_pkg::CFG_SYNC_BYTE:   sync_byte_reg   <= cfg_data;
                stld_pkg::CFG_MAX_PAYLOAD: max_payload_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    assign cfg.sync_byte   = sync_byte_reg;
    assign cfg.max_payload = max_payload_reg;

endmodule

@@ rtl/core/stld_in_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stld_in_stage
// Input register: captures one received beat and holds it for the parser.
// ----------------------------------------------------------------------------
module stld_in_stage
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  stld_pkg::stld_in_t    in_data,
    input  logic                  adv,
    output stld_pkg::stld_stage_t stage
);

    logic               valid_reg;
    stld_pkg::stld_in_t beat_reg;

    // free when empty or when the held beat moves on this cycle
    assign in_ready = !valid_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            beat_reg <= in_data;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.beat  = beat_reg;

endmodule

@@ rtl/core/stld_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stld_parser
// Frame state machine and result register: one beat per cycle unless a stalled result holds it.
// ----------------------------------------------------------------------------
module stld_parser
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  stld_pkg::stld_stage_t stage,
    input  stld_pkg::stld_cfg_t   cfg,
    output logic                  adv,
    output logic                  out_valid,
    input  logic                  out_ready,
    output stld_pkg::stld_out_t   out_data
);

    stld_pkg::stld_phase_t phase_reg, phase_next;
    logic [7:0]            type_reg, type_next;
    logic [7:0]            size_reg, size_next;
    logic [6:0]            count_reg, count_next;
    logic                  out_valid_reg;
    stld_pkg::stld_out_t   out_reg;

    logic                  fire;
    logic                  res_valid;
    stld_pkg::stld_out_t   res;
    logic [7:0]            b;
    logic                  eop;
    logic [7:0]            limit;
    logic [6:0]            count_inc;
    logic                  payload_done;

    assign adv  = !out_valid_reg || out_ready;
    assign fire = stage.valid && adv;
    assign b    = stage.beat.rx_byte;
    assign eop  = stage.beat.end_of_packet;

    assign limit = ({1'b0, cfg.max_payload} > 8'(stld_pkg::PAYLOAD_LIMIT))
                 ? 8'(stld_pkg::PAYLOAD_LIMIT) : {1'b0, cfg.max_payload};

    assign count_inc    = count_reg + 7'd1;
    assign payload_done = {1'b0, count_inc} >= size_reg;

    always_comb
    begin
        phase_next = phase_reg;
        type_next  = type_reg;
        size_next  = size_reg;
        count_next = count_reg;
        res_valid  = 1'b0;
        res              = '0;
        res.message_type = type_reg;
        res.message_size = size_reg;
        res.status       = stld_pkg::ST_BUSY;

        case (phase_reg)
            stld_pkg::PH_TYPE:
            begin
                type_next        = b;
                res.message_type = b;
                if (eop)
                begin
                    phase_next = stld_pkg::PH_HUNT;
                    res_valid  = 1'b1;
                    res.status = stld_pkg::ST_ERR;
                end
                else
                begin
                    phase_next = stld_pkg::PH_SIZE;
                end
            end

            stld_pkg::PH_SIZE:
            begin
                size_next        = b;
                count_next       = '0;
                res.message_size = b;
                if (b > limit)
                begin
                    phase_next = eop ? stld_pkg::PH_HUNT : stld_pkg::PH_SKIP;
                    res_valid  = 1'b1;
                    res.status = stld_pkg::ST_ERR;
                end
                else if (b == 8'd0)
                begin
                    phase_next = eop ? stld_pkg::PH_HUNT : stld_pkg::PH_SKIP;
                    res_valid  = 1'b1;
                    res.status = stld_pkg::ST_DONE;
                end
                else if (eop)
                begin
                    phase_next = stld_pkg::PH_HUNT;
                    res_valid  = 1'b1;
                    res.status = stld_pkg::ST_ERR;
                end
                else
                begin
                    phase_next = stld_pkg::PH_DATA;
                end
            end

            stld_pkg::PH_DATA:
            begin
                count_next       = count_inc;
                res_valid        = 1'b1;
                res.data_valid   = 1'b1;
                res.payload_byte = b;
                res.byte_index   = count_reg[5:0];
                if (payload_done)
                begin
                    res.status = stld_pkg::ST_DONE;
                    phase_next = eop ? stld_pkg::PH_HUNT : stld_pkg::PH_SKIP;
                end
                else if (eop)
                begin
                    // packet ended short of the declared size
                    res.status = stld_pkg::ST_ERR;
                    phase_next = stld_pkg::PH_HUNT;
                end
            end

            stld_pkg::PH_SKIP:
            begin
                if (eop)
                begin
                    phase_next = stld_pkg::PH_HUNT;
                end
            end

            default:
            begin
                phase_next       = stld_pkg::PH_HUNT;
                res.message_type = '0;
                res.message_size = '0;
                if (b == cfg.sync_byte)
                begin
                    type_next  = '0;
                    size_next  = '0;
                    count_next = '0;
                    if (eop)
                    begin
                        res_valid  = 1'b1;
                        res.status = stld_pkg::ST_ERR;
                    end
                    else
                    begin
                        phase_next = stld_pkg::PH_TYPE;
                    end
                end
                else if (eop)
                begin
                    // no start byte anywhere in the packet
                    res_valid  = 1'b1;
                    res.status = stld_pkg::ST_ERR;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= stld_pkg::PH_HUNT;
            type_reg      <= '0;
            size_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                phase_reg <= phase_next;
                type_reg  <= type_next;
                size_reg  <= size_next;
                count_reg <= count_next;
            end
            if (adv)
            begin
                out_valid_reg <= fire && res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ rtl/core/sync_type_length_deframer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_type_length_deframer_core
// Parses start/type/size/payload messages out of a stream of packet bytes.
// ----------------------------------------------------------------------------
// Input channel: one received byte per beat, marked when it ends its packet.
// Output channel: one result beat per payload byte, per completed message
// with empty payload, and per frame error; other bytes give no result.
// Configuration channel: index 0 is the start byte, index 1 the payload
// size limit (clamped to 64). Write only while the block is idle.
// Path: an accepted input beat passes through the input register, then
// the result register, before its result beat is presented.
// Throughput: one beat per cycle while the receiver takes results; the
// frame state update is combinational compare logic between the registers.
// Reset: the parser hunts for a start byte, held type and size are zero,
// and the configuration returns to start byte 0xAA and limit 64.
// Receiver stall: the result register holds its beat; an empty input
// register takes one further input beat, then in_ready drops.
// ----------------------------------------------------------------------------
module sync_type_length_deframer_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  stld_pkg::stld_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output stld_pkg::stld_out_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [0:0]          cfg_index,
    input  logic [7:0]          cfg_data
);

    stld_pkg::stld_cfg_t   cfg;
    stld_pkg::stld_stage_t stage;
    logic                  adv;

    stld_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    stld_in_stage u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .adv      (adv),
        .stage    (stage)
    );

    stld_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage     (stage),
        .cfg       (cfg),
        .adv       (adv),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ rtl/core/stld_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stld_port_checks
// Port-level checks on the result channel of the deframer.
// ----------------------------------------------------------------------------
module stld_port_checks
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input stld_pkg::stld_out_t out_data
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // beats without payload carry zero byte and index
    a_no_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.data_valid |->
            out_data.payload_byte == 8'd0 && out_data.byte_index == 6'd0)
        else $error("payload fields set without data");

    // a beat without payload always closes a message
    a_no_data_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.data_valid |-> out_data.status != stld_pkg::ST_BUSY)
        else $error("empty beat reported in progress");

    // the completing payload byte is the last one of the declared size
    a_done_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.data_valid && out_data.status == stld_pkg::ST_DONE |->
            out_data.byte_index == 6'(out_data.message_size - 8'd1))
        else $error("message completed at wrong index");

endmodule

bind sync_type_length_deframer_core stld_port_checks u_stld_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
